### rtl/kbmhs_pkg.sv
// Shared payload types and field widths for the k-best max-heap selector.
package kbmhs_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Register indexes
    localparam logic REG_K_LIMIT = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   item_id;
        logic [DIST_W-1:0] dist_sq;
    } t_req;

    typedef struct packed {
        logic [DIST_W-1:0] worst_dist;
        logic [CNT_W-1:0]  held_count;
        logic [ID_W-1:0]   out_id;
        logic [DIST_W-1:0] out_dist;
        logic              out_valid;
        logic              last;
    } t_result;

endpackage

### rtl/k_best_max_heap_selector.sv
// Top level of the k-best max-heap selector: keeps the k smallest distances.
// Usage: raise start with a request on i_req while busy is low; the request is
// taken at that edge. A push (req_type 0) inserts a candidate into a bounded
// max-heap or replaces the root when strictly smaller, then gives one result
// with the current worst kept distance (all ones while not full) and the
// count held. A flush (req_type 1) sorts the heap ascending, stably, gives one
// result per entry (last marks the final one, or one empty result if nothing
// is held) and empties the heap. Results appear on o_result for exactly one
// cycle with o_strobe high; the receiver cannot hold them off.
// Datapath: one heap memory port serves every step, one memory read per cycle.
// A growing push sifts the new entry up toward the root; a replacing push
// sifts the new root down (at most 4 levels for 16 entries); a rejected push
// only gives its result. A flush insertion-sorts the held entries, then emits
// them in order. A new request can transfer while the last result of the
// previous one is shown. k_limit is written through the APB port (address 0);
// the user must write it only while idle, the block does not enforce this.
// Reset sets k_limit to 16, empties the heap (only the fill count, not the
// memory) and drops any pending result.
module k_best_max_heap_selector #(
    parameter int CAPACITY   = 16,
    parameter int DIST_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  kbmhs_pkg::t_req               i_req,
    output logic                          busy,
    output logic                          o_strobe,
    output kbmhs_pkg::t_result            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kbmhs_pkg::APB_AW-1:0]  paddr,
    input  logic [kbmhs_pkg::APB_DW-1:0]  pwdata,
    output logic [kbmhs_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW  = DIST_WIDTH + kbmhs_pkg::ID_W;
    localparam int XW  = 6;                          // heap index incl. child overflow
    localparam int CW  = kbmhs_pkg::CNT_W;
    localparam logic [6:0] CAP7 = 7'(CAPACITY);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_UP_RD  = 13'b0000000000010,
        S_UP_CMP = 13'b0000000000100,
        S_DN_RDL = 13'b0000000001000,
        S_DN_RDR = 13'b0000000010000,
        S_DN_CMP = 13'b0000000100000,
        S_SR_KRD = 13'b0000001000000,
        S_SR_KLD = 13'b0000010000000,
        S_SR_CMP = 13'b0000100000000,
        S_SR_RD  = 13'b0001000000000,
        S_EM_RD  = 13'b0010000000000,
        S_EM_OUT = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    // Heap memory: {dist, id} per slot
    logic [EW-1:0] mem [CAPACITY];

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_fill, n_fill;
    logic [CW-1:0]          r_k;
    logic [CW-1:0]          r_n, n_n;
    logic [XW-1:0]          r_i, n_i;
    logic [XW-1:0]          r_j, n_j;
    logic [DIST_WIDTH-1:0]  r_key_dist, n_key_dist;
    logic [kbmhs_pkg::ID_W-1:0] r_key_id, n_key_id;
    logic [EW-1:0]          r_aux, n_aux;
    logic [EW-1:0]          r_rd_data;
    logic [DIST_WIDTH-1:0]  r_root;
    kbmhs_pkg::t_result     r_out, n_out;
    logic                   r_out_stb, n_out_stb;

    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    logic [EW-1:0]          w_wdata;
    logic [IW-1:0]          w_raddr;

    logic                   w_accept;
    logic                   w_cfg_wr;
    logic [CW-1:0]          w_k1;
    logic [CW-1:0]          w_k_eff;
    logic [DIST_WIDTH-1:0]  w_in_dist;
    logic [kbmhs_pkg::DIST_W-1:0] w_mask32;
    logic [kbmhs_pkg::DIST_W-1:0] w_worst;
    logic [XW-1:0]          w_fill_x;
    logic [XW-1:0]          w_n_x;
    logic [XW-1:0]          w_parent;
    logic [XW-1:0]          w_lchild;
    logic [XW-1:0]          w_rchild;
    logic [XW-1:0]          w_i_inc;
    logic [XW-1:0]          w_i_dec;
    logic [XW-1:0]          w_j_dec;
    logic [DIST_WIDTH-1:0]  w_rd_dist;
    logic [DIST_WIDTH-1:0]  w_aux_dist;
    logic                   w_l_gt;
    logic [DIST_WIDTH-1:0]  w_best_dist;
    logic                   w_r_ok;
    logic                   w_r_gt;
    logic [EW-1:0]          w_key;

    assign w_accept  = start && !busy;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_out_stb;
    assign o_result  = r_out;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == kbmhs_pkg::REG_K_LIMIT) ?
                       {{(kbmhs_pkg::APB_DW-CW){1'b0}}, r_k} : '0;

    // Effective k: zero reads as one, saturate at the heap capacity
    assign w_k1    = (r_k == '0) ? CW'(1) : r_k;
    assign w_k_eff = ({2'b00, w_k1} > CAP7) ? CW'(CAPACITY) : w_k1;

    assign w_in_dist = DIST_WIDTH'(i_req.dist_sq);
    assign w_mask32  = kbmhs_pkg::DIST_W'({DIST_WIDTH{1'b1}});
    assign w_worst   = ((r_fill < w_k_eff) || (r_fill == '0)) ? w_mask32 :
                       kbmhs_pkg::DIST_W'(r_root);

    assign w_fill_x  = {1'b0, r_fill};
    assign w_n_x     = {1'b0, r_n};
    assign w_parent  = (r_i - XW'(1)) >> 1;
    assign w_lchild  = {r_i[XW-2:0], 1'b1};
    assign w_rchild  = w_lchild + XW'(1);
    assign w_i_inc   = r_i + XW'(1);
    assign w_i_dec   = r_i - XW'(1);
    assign w_j_dec   = r_j - XW'(1);

    assign w_rd_dist   = r_rd_data[EW-1:kbmhs_pkg::ID_W];
    assign w_aux_dist  = r_aux[EW-1:kbmhs_pkg::ID_W];
    assign w_key       = {r_key_dist, r_key_id};

    // Sift-down selection: larger child, strict compare, left wins ties
    assign w_l_gt      = w_aux_dist > r_key_dist;
    assign w_best_dist = w_l_gt ? w_aux_dist : r_key_dist;
    assign w_r_ok      = w_rchild < w_fill_x;
    assign w_r_gt      = w_r_ok && (w_rd_dist > w_best_dist);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_key_dist = r_key_dist;
        n_key_id   = r_key_id;
        n_aux      = r_aux;
        n_out      = r_out;
        n_out_stb  = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_i[IW-1:0];
        w_wdata    = w_key;
        w_raddr    = r_i[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key_dist = w_in_dist;
                    n_key_id   = i_req.item_id;
                    if (i_req.req_type == kbmhs_pkg::REQ_PUSH) begin
                        if (r_fill < w_k_eff) begin
                            n_i     = w_fill_x;
                            n_fill  = r_fill + CW'(1);
                            n_state = S_UP_RD;
                        end else if (w_in_dist < r_root) begin
                            n_i     = '0;
                            n_state = S_DN_RDL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_n    = r_fill;
                        n_fill = '0;
                        if (r_fill == '0) begin
                            // empty flush: one result, nothing to sort
                            n_out     = '{worst_dist: w_mask32, held_count: '0,
                                          out_id: '0, out_dist: '0,
                                          out_valid: 1'b0, last: 1'b1};
                            n_out_stb = 1'b1;
                        end else if (r_fill == CW'(1)) begin
                            n_i     = '0;
                            n_state = S_EM_RD;
                        end else begin
                            n_i     = XW'(1);
                            n_state = S_SR_KRD;
                        end
                    end
                end
            end
            // Sift up: move smaller parents down, drop key in the hole
            S_UP_RD: begin
                if (r_i == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr = w_parent[IW-1:0];
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_rd_dist < r_key_dist) begin
                    w_wdata = r_rd_data;
                    n_i     = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            // Sift down from the root after a replacement
            S_DN_RDL: begin
                if (w_lchild < w_fill_x) begin
                    w_raddr = w_lchild[IW-1:0];
                    n_state = S_DN_RDR;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_DN_RDR: begin
                n_aux   = r_rd_data;
                w_raddr = w_rchild[IW-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_r_gt) begin
                    w_wdata = r_rd_data;
                    n_i     = w_rchild;
                    n_state = S_DN_RDL;
                end else if (w_l_gt) begin
                    w_wdata = r_aux;
                    n_i     = w_lchild;
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_FIN;
                end
            end
            // Stable insertion sort: shift strictly larger entries right
            S_SR_KRD: begin
                n_state = S_SR_KLD;
            end
            S_SR_KLD: begin
                n_key_dist = w_rd_dist;
                n_key_id   = r_rd_data[kbmhs_pkg::ID_W-1:0];
                n_j        = r_i;
                w_raddr    = w_i_dec[IW-1:0];
                n_state    = S_SR_CMP;
            end
            S_SR_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_j[IW-1:0];
                if (w_rd_dist > r_key_dist) begin
                    w_wdata = r_rd_data;
                    n_j     = w_j_dec;
                    n_state = S_SR_RD;
                end else if (w_i_inc == w_n_x) begin
                    n_i     = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_i     = w_i_inc;
                    n_state = S_SR_KRD;
                end
            end
            S_SR_RD: begin
                if (r_j == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    if (w_i_inc == w_n_x) begin
                        n_i     = '0;
                        n_state = S_EM_RD;
                    end else begin
                        n_i     = w_i_inc;
                        n_state = S_SR_KRD;
                    end
                end else begin
                    w_raddr = w_j_dec[IW-1:0];
                    n_state = S_SR_CMP;
                end
            end
            // Emit one sorted entry per cycle, prefetching the next
            S_EM_RD: begin
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                n_out     = '{worst_dist: w_mask32, held_count: '0,
                              out_id: r_rd_data[kbmhs_pkg::ID_W-1:0],
                              out_dist: kbmhs_pkg::DIST_W'(w_rd_dist),
                              out_valid: 1'b1, last: (w_i_inc == w_n_x)};
                n_out_stb = 1'b1;
                n_i       = w_i_inc;
                w_raddr   = w_i_inc[IW-1:0];
                if (w_i_inc == w_n_x) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                n_out     = '{worst_dist: w_worst, held_count: r_fill,
                              out_id: '0, out_dist: '0,
                              out_valid: 1'b0, last: 1'b1};
                n_out_stb = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Heap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    // Mirror of the root distance, kept in step with every slot-0 write
    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata[EW-1:kbmhs_pkg::ID_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_k       <= CW'(16);
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_out_stb <= n_out_stb;
            if (w_cfg_wr && (paddr[2] == kbmhs_pkg::REG_K_LIMIT)) begin
                r_k <= pwdata[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_key_dist <= n_key_dist;
        r_key_id   <= n_key_id;
        r_aux      <= n_aux;
        r_out      <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_strobe))
        else $error("accepted request neither started work nor gave a result");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.out_valid) |-> o_result.last)
        else $error("result without an entry is not marked last");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b00, r_fill} <= CAP7))
        else $error("fill count exceeds heap capacity");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the k-best max-heap selector.
`timescale 1ns / 1ps

module tb;
    import kbmhs_pkg::*;

    localparam int unsigned HEAP_SLOTS   = 16;
    localparam int unsigned REG_UNMAPPED = 1;        // index with no register behind it
    localparam int unsigned RUN_LIMIT    = 300000;   // cycles before the run is declared hung
    localparam int unsigned TAIL_CYCLES  = 400;      // longer than a full 16-entry flush

    // Distance styles for random pushes
    localparam int unsigned DIST_WIDE    = 0;
    localparam int unsigned DIST_NARROW  = 1;
    localparam int unsigned DIST_EDGES   = 2;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    t_req                 i_req   = '0;
    logic                 busy;
    logic                 o_strobe;
    t_result              o_result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [APB_AW-1:0]    paddr   = '0;
    logic [APB_DW-1:0]    pwdata  = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Shadow copy of the heap, the fill count and the keep limit.
    logic [DIST_W-1:0]    kept_dist [HEAP_SLOTS];
    logic [ID_W-1:0]      kept_id   [HEAP_SLOTS];
    int unsigned          kept_count  = 0;
    logic [CNT_W-1:0]     keep_limit  = 5'd16;

    // Results the block still owes us, oldest first.
    t_result              due_replies [$];

    int unsigned          fault_count = 0;
    int unsigned          cycle_count = 0;
    int unsigned          idle_pct    = 0;

    k_best_max_heap_selector u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // Hang guard: give up well past the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** k_best_max_heap_selector: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Heap shadow
    // ------------------------------------------------------------------

    function automatic void swap_kept(input int unsigned a, input int unsigned b);
        logic [DIST_W-1:0] td;
        logic [ID_W-1:0]   ti;
        td           = kept_dist[a];
        ti           = kept_id[a];
        kept_dist[a] = kept_dist[b];
        kept_id[a]   = kept_id[b];
        kept_dist[b] = td;
        kept_id[b]   = ti;
    endfunction

    // Apply one accepted request to the shadow heap and queue what it must emit.
    task automatic heap_apply(input t_req rq);
        t_result           rsp;
        int unsigned       lim, slot, parent, big, lch, rch, n, i, j;
        logic              settled;
        logic [DIST_W-1:0] hold_d;
        logic [ID_W-1:0]   hold_id;
        rsp = '0;
        if (rq.req_type == REQ_PUSH) begin
            // Zero means one, anything past the capacity clamps to it.
            lim = (keep_limit == 0) ? 1 :
                  ((keep_limit > HEAP_SLOTS) ? HEAP_SLOTS : int'(keep_limit));
            if (kept_count < lim) begin
                // Grow: append, then bubble toward the root.
                slot            = kept_count;
                kept_dist[slot] = rq.dist_sq;
                kept_id[slot]   = rq.item_id;
                kept_count++;
                settled = 1'b0;
                while (slot > 0 && !settled) begin
                    parent = (slot - 1) / 2;
                    if (kept_dist[parent] < kept_dist[slot]) begin
                        swap_kept(parent, slot);
                        slot = parent;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end else if (rq.dist_sq < kept_dist[0]) begin
                // Full: evict the root only on a strictly smaller distance,
                // then sink over every entry held (may exceed a lowered limit).
                kept_dist[0] = rq.dist_sq;
                kept_id[0]   = rq.item_id;
                slot         = 0;
                settled      = 1'b0;
                while (!settled) begin
                    big = slot;
                    lch = 2 * slot + 1;
                    rch = 2 * slot + 2;
                    if (lch < kept_count && kept_dist[lch] > kept_dist[big]) big = lch;
                    if (rch < kept_count && kept_dist[rch] > kept_dist[big]) big = rch;
                    if (big == slot) begin
                        settled = 1'b1;
                    end else begin
                        swap_kept(slot, big);
                        slot = big;
                    end
                end
            end
            rsp.worst_dist = (kept_count < lim) ? '1 : kept_dist[0];
            rsp.held_count = kept_count[CNT_W-1:0];
            rsp.last       = 1'b1;
            due_replies.push_back(rsp);
        end else begin
            // Flush: stable insertion sort of the array as it stands, emit, clear.
            n = kept_count;
            for (i = 1; i < n; i++) begin
                hold_d  = kept_dist[i];
                hold_id = kept_id[i];
                j = i;
                while (j > 0 && kept_dist[j-1] > hold_d) begin
                    kept_dist[j] = kept_dist[j-1];
                    kept_id[j]   = kept_id[j-1];
                    j--;
                end
                kept_dist[j] = hold_d;
                kept_id[j]   = hold_id;
            end
            kept_count     = 0;
            rsp.worst_dist = '1;
            if (n == 0) begin
                rsp.last = 1'b1;
                due_replies.push_back(rsp);
            end
            for (i = 0; i < n; i++) begin
                rsp.out_id    = kept_id[i];
                rsp.out_dist  = kept_dist[i];
                rsp.out_valid = 1'b1;
                rsp.last      = (i + 1 == n);
                due_replies.push_back(rsp);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed result.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : reply_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_replies.size() == 0) begin
                $display("%0t: result with nothing owed: expected none, actual %h",
                         $time, o_result);
                fault_count++;
            end else begin
                want = due_replies.pop_front();
                if (o_result.worst_dist !== want.worst_dist) begin
                    $display("%0t: worst_dist expected %h actual %h",
                             $time, want.worst_dist, o_result.worst_dist);
                    fault_count++;
                end
                if (o_result.held_count !== want.held_count) begin
                    $display("%0t: held_count expected %0d actual %0d",
                             $time, want.held_count, o_result.held_count);
                    fault_count++;
                end
                if (o_result.out_id !== want.out_id) begin
                    $display("%0t: out_id expected %h actual %h",
                             $time, want.out_id, o_result.out_id);
                    fault_count++;
                end
                if (o_result.out_dist !== want.out_dist) begin
                    $display("%0t: out_dist expected %h actual %h",
                             $time, want.out_dist, o_result.out_dist);
                    fault_count++;
                end
                if (o_result.out_valid !== want.out_valid) begin
                    $display("%0t: out_valid expected %b actual %b",
                             $time, want.out_valid, o_result.out_valid);
                    fault_count++;
                end
                if (o_result.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, o_result.last);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends on a rising edge.
    // ------------------------------------------------------------------

    function automatic t_req make_push(input logic [ID_W-1:0] id,
                                       input logic [DIST_W-1:0] d);
        t_req rq;
        rq.req_type = REQ_PUSH;
        rq.item_id  = id;
        rq.dist_sq  = d;
        return rq;
    endfunction

    // Id and distance are don't-care on a flush; randomize them anyway.
    function automatic t_req make_flush();
        t_req rq;
        rq.req_type = REQ_FLUSH;
        rq.item_id  = ID_W'($urandom);
        rq.dist_sq  = DIST_W'($urandom);
        return rq;
    endfunction

    // Hold start with the request until the transfer, idling first at random.
    task automatic send_request(input t_req rq);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        heap_apply(rq);
    endtask

    // Drop start and wait until every owed result is in and the block is idle.
    task automatic drain_replies();
        start <= 1'b0;
        while (due_replies.size() != 0 || busy) @(posedge i_clk);
    endtask

    // One APB transfer: setup, access until pready, then an idle phase.
    task automatic apb_access(input logic wr, input int unsigned index,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(4 * index);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, mirror it, and read the keep limit back.
    task automatic write_register(input int unsigned index, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, index, value, rd);
        if (index == int'(REG_K_LIMIT)) keep_limit = value[CNT_W-1:0];
        apb_access(1'b0, int'(REG_K_LIMIT), '0, rd);
        if (rd !== APB_DW'(keep_limit)) begin
            $display("%0t: k_limit readback expected %h actual %h",
                     $time, APB_DW'(keep_limit), rd);
            fault_count++;
        end
    endtask

    function automatic logic [DIST_W-1:0] pick_distance(input int unsigned style);
        case (style)
            DIST_NARROW: return DIST_W'($urandom_range(15));
            DIST_EDGES: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return DIST_W'(1);
                    2:       return {{(DIST_W-1){1'b1}}, 1'b0};
                    default: return '1;
                endcase
            end
            default:     return DIST_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of the limit, and a flush with nothing held.
    task automatic test_after_reset();
        write_register(REG_UNMAPPED, '0);
        send_request(make_flush());
        drain_replies();
    endtask

    // Extremes of id and distance, plus ties that the sort must keep in order.
    task automatic test_field_extremes();
        send_request(make_push(16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_push(16'h0000, 32'h0000_0000));
        send_request(make_push(16'h1234, 32'h0000_0005));
        send_request(make_push(16'hABCD, 32'h0000_0005));
        send_request(make_push(16'h5555, 32'h0000_0000));
        send_request(make_flush());
        drain_replies();
    endtask

    // Zero limit acts as one; equal distance is ignored; oversize limit clamps.
    task automatic test_keep_limit_edges();
        write_register(int'(REG_K_LIMIT), 32'd0);
        send_request(make_push(16'd1, 32'd100));
        send_request(make_push(16'd2, 32'd100));
        send_request(make_push(16'd3, 32'd50));
        send_request(make_push(16'd4, 32'hFFFF_FFFF));
        send_request(make_flush());
        drain_replies();
        write_register(int'(REG_K_LIMIT), 32'd31);
        send_request(make_push(16'd7, 32'h8000_0000));
        send_request(make_push(16'd8, 32'h0000_0010));
        drain_replies();
    endtask

    // Shrink the limit below the fill: nothing is dropped, the root is replaced.
    task automatic test_lowered_limit();
        send_request(make_push(16'd9,  32'h0000_0020));
        send_request(make_push(16'd10, 32'h7FFF_FFFF));
        send_request(make_push(16'd11, 32'h0000_0010));
        drain_replies();
        write_register(int'(REG_K_LIMIT), 32'd2);
        send_request(make_push(16'd12, 32'h9000_0000));
        send_request(make_push(16'd13, 32'h0000_0015));
        send_request(make_flush());
        drain_replies();
    endtask

    // Writes to the unmapped index are ignored; upper data bits are dropped.
    task automatic test_register_map();
        write_register(REG_UNMAPPED, 32'd1);
        write_register(int'(REG_K_LIMIT), 32'hFFFF_FFE3);
    endtask

    // Mostly push bursts closed by a flush, with some loose requests mixed in.
    task automatic run_random_stretch(input logic [APB_DW-1:0] limit_value,
                                      input int unsigned budget);
        int unsigned sent, burst, style;
        t_req        rq;
        write_register(int'(REG_K_LIMIT), limit_value);
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 80) begin
                burst = $urandom_range(19);
                style = $urandom_range(DIST_EDGES, DIST_WIDE);
                repeat (burst) begin
                    send_request(make_push(ID_W'($urandom), pick_distance(style)));
                    sent++;
                end
                send_request(make_flush());
                sent++;
            end else begin
                rq.req_type = ($urandom_range(1) == 0) ? REQ_PUSH : REQ_FLUSH;
                rq.item_id  = ID_W'($urandom);
                rq.dist_sq  = DIST_W'($urandom);
                send_request(rq);
                sent++;
            end
        end
        drain_replies();
    endtask

    // Three idling regimes, two limit settings in each.
    task automatic test_random_traffic();
        idle_pct = 36;
        run_random_stretch(32'd31, 12);
        run_random_stretch(32'd7, 12);
        idle_pct = 66;
        run_random_stretch(32'd1, 12);
        run_random_stretch(APB_DW'($urandom_range(2, 15)), 12);
        idle_pct = 0;
        run_random_stretch(32'd16, 12);
        run_random_stretch(APB_DW'($urandom_range(31)), 12);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 36;
        test_after_reset();
        test_field_extremes();
        test_keep_limit_edges();
        test_lowered_limit();
        test_register_map();
        test_random_traffic();

        // Flush whatever is still held so the tail is checked too.
        send_request(make_flush());
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("** k_best_max_heap_selector: PASSED **");
        end else begin
            $display("** k_best_max_heap_selector: FAILED **");
        end
        $finish;
    end

endmodule
